>>> src/sbca_pkg.sv
// Shared types and constants for the 16-bit CPU ALU.
// No dependencies; the ALU top level, divider stage and checker in src use it.
package sbca_pkg;

    localparam int WORD_W     = 16;
    localparam int DIVD_W     = 2 * WORD_W;
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS  = DIVD_W / DIV_STAGES;
    // First divider stage whose input already holds a % b (after WORD_W steps).
    localparam int MOD_STAGE  = WORD_W / DIV_STEPS;
    // Decode register + divider stages + output register.
    localparam int PIPE_DEPTH = DIV_STAGES + 2;

    typedef enum logic [3:0] {
        OP_NONBASIC = 4'd0,
        OP_SET      = 4'd1,
        OP_ADD      = 4'd2,
        OP_SUB      = 4'd3,
        OP_MUL      = 4'd4,
        OP_DIV      = 4'd5,
        OP_MOD      = 4'd6,
        OP_SHL      = 4'd7,
        OP_SHR      = 4'd8,
        OP_AND      = 4'd9,
        OP_BOR      = 4'd10,
        OP_XOR      = 4'd11,
        OP_IFE      = 4'd12,
        OP_IFN      = 4'd13,
        OP_IFG      = 4'd14,
        OP_IFB      = 4'd15
    } opcode_t;

    // Per-item results that ride alongside the divider.
    typedef struct packed {
        opcode_t             op;
        logic                b_zero;
        logic [WORD_W-1:0]   side_res;
        logic [WORD_W-1:0]   side_ovf;
        logic                wr;
        logic                wo;
        logic                skip;
        logic [DIVD_W-1:0]   product;
        logic [WORD_W-1:0]   mod_rem;
    } info_t;

    // Restoring divider state: quotient bits fill word from the bottom
    // while dividend bits leave from the top.
    typedef struct packed {
        logic [WORD_W-1:0]   divisor;
        logic [WORD_W-1:0]   rem;
        logic [DIVD_W-1:0]   word;
        info_t               info;
    } div_state_t;

endpackage

>>> src/sbca_in_if.sv
// Instruction channel of the 16-bit CPU ALU: valid/ready plus operands.
// Plain widths; no package dependency.
interface sbca_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [15:0] a_value;
    logic [15:0] b_value;

    modport source (output valid, output cmd, output a_value, output b_value, input ready);
    modport sink   (input valid, input cmd, input a_value, input b_value, output ready);
endinterface

>>> src/sbca_out_if.sv
// Result channel of the 16-bit CPU ALU: valid/ready plus result fields.
// Plain widths; no package dependency.
interface sbca_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_value;
    logic        writes_result;
    logic [15:0] overflow_value;
    logic        writes_overflow;
    logic        skip_next;

    modport source (output valid, output result_value, output writes_result,
                    output overflow_value, output writes_overflow, output skip_next,
                    input ready);
    modport sink   (input valid, input result_value, input writes_result,
                    input overflow_value, input writes_overflow, input skip_next,
                    output ready);
endinterface

>>> src/sixteen_bit_cpu_alu.sv
// Basic-instruction ALU of a 16-bit CPU: set, add, sub, mul, div, mod, shifts,
// logic ops and the four conditional tests. Depends on sbca_pkg, sbca_div_stage and
// the channel interfaces. Pipeline: decode/multiply register, 8 divider stages,
// output register. Throughput: one item per cycle while the output is not stalled;
// the 32-step restoring divider runs 4 steps in each of its 8 stages.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty.
module sixteen_bit_cpu_alu (
    input  logic        clk,
    input  logic        rst_n,
    sbca_in_if.sink     instr,
    sbca_out_if.source  result
);

    localparam int W  = sbca_pkg::WORD_W;
    localparam int NS = sbca_pkg::DIV_STAGES;
    localparam int PD = sbca_pkg::PIPE_DEPTH;

    // ------------------------------------------------------------------
    // Stall control. Each stage loads when it is empty or the stage after
    // it loads, so bubbles are squeezed out even while the output waits.
    // Index 0 is the decode register, 1..NS the divider, PD-1 the output.
    // ------------------------------------------------------------------
    logic [PD-1:0] pipe_valid;
    logic [PD-1:0] adv;

    always_comb
    begin
        adv[PD-1] = !pipe_valid[PD-1] || result.ready;
        for (int k = PD - 2; k >= 0; k--)
            adv[k] = !pipe_valid[k] || adv[k+1];
    end

    assign instr.ready = adv[0];

    // ------------------------------------------------------------------
    // Stage 1: decode, simple ops, shifts, 16x16 multiply.
    // ------------------------------------------------------------------
    sbca_pkg::opcode_t    op;
    logic [W:0]           sum;
    logic [W:0]           dif;
    logic [2*W-1:0]       shl_word;
    logic [2*W-1:0]       shr_word;
    logic                 big_shift;
    sbca_pkg::info_t      info_next;
    sbca_pkg::div_state_t s1_state_next;
    sbca_pkg::div_state_t s1_state_reg;
    logic                 s1_valid_next;
    logic                 s1_valid_reg;

    assign op        = sbca_pkg::opcode_t'(instr.cmd);
    assign sum       = {1'b0, instr.a_value} + {1'b0, instr.b_value};
    assign dif       = {1'b0, instr.a_value} - {1'b0, instr.b_value};
    // Shift amounts of 32 or more clear both words.
    assign big_shift = |instr.b_value[W-1:5];
    assign shl_word  = {{W{1'b0}}, instr.a_value} << instr.b_value[4:0];
    assign shr_word  = {instr.a_value, {W{1'b0}}} >> instr.b_value[4:0];

    always_comb
    begin
        info_next          = '0;
        info_next.op       = op;
        info_next.b_zero   = (instr.b_value == '0);
        info_next.product  = {{W{1'b0}}, instr.a_value} * {{W{1'b0}}, instr.b_value};
        unique case (op) inside
            sbca_pkg::OP_NONBASIC: ;
            sbca_pkg::OP_SET:
            begin
                info_next.side_res = instr.b_value;
                info_next.wr       = 1'b1;
            end
            sbca_pkg::OP_ADD:
            begin
                info_next.side_res = sum[W-1:0];
                info_next.side_ovf = {{(W-1){1'b0}}, sum[W]};
                info_next.wr       = 1'b1;
                info_next.wo       = 1'b1;
            end
            sbca_pkg::OP_SUB:
            begin
                info_next.side_res = dif[W-1:0];
                info_next.side_ovf = {W{dif[W]}};   // borrow gives all ones
                info_next.wr       = 1'b1;
                info_next.wo       = 1'b1;
            end
            sbca_pkg::OP_MUL, sbca_pkg::OP_DIV:
            begin
                info_next.wr = 1'b1;
                info_next.wo = 1'b1;
            end
            sbca_pkg::OP_MOD:
                info_next.wr = 1'b1;
            sbca_pkg::OP_SHL:
            begin
                if (!big_shift)
                begin
                    info_next.side_res = shl_word[W-1:0];
                    info_next.side_ovf = shl_word[2*W-1:W];
                end
                info_next.wr = 1'b1;
                info_next.wo = 1'b1;
            end
            sbca_pkg::OP_SHR:
            begin
                if (!big_shift)
                begin
                    info_next.side_res = shr_word[2*W-1:W];
                    info_next.side_ovf = shr_word[W-1:0];
                end
                info_next.wr = 1'b1;
                info_next.wo = 1'b1;
            end
            sbca_pkg::OP_AND:
            begin
                info_next.side_res = instr.a_value & instr.b_value;
                info_next.wr       = 1'b1;
            end
            sbca_pkg::OP_BOR:
            begin
                info_next.side_res = instr.a_value | instr.b_value;
                info_next.wr       = 1'b1;
            end
            sbca_pkg::OP_XOR:
            begin
                info_next.side_res = instr.a_value ^ instr.b_value;
                info_next.wr       = 1'b1;
            end
            sbca_pkg::OP_IFE: info_next.skip = (instr.a_value != instr.b_value);
            sbca_pkg::OP_IFN: info_next.skip = (instr.a_value == instr.b_value);
            sbca_pkg::OP_IFG: info_next.skip = (instr.a_value <= instr.b_value);
            sbca_pkg::OP_IFB: info_next.skip = ((instr.a_value & instr.b_value) == '0);
            default: ;
        endcase
    end

    // Divider seed: dividend a << 16. The top half of the 32-bit quotient
    // is a / b, the bottom half the overflow word.
    always_comb
    begin
        s1_state_next.divisor = instr.b_value;
        s1_state_next.rem     = '0;
        s1_state_next.word    = {instr.a_value, {W{1'b0}}};
        s1_state_next.info    = info_next;
    end

    assign s1_valid_next = adv[0] ? instr.valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            s1_state_reg <= s1_state_next;
    end

    assign pipe_valid[0] = s1_valid_reg;

    // ------------------------------------------------------------------
    // Divider pipeline. After the first 16 steps the partial remainder
    // is a % b; it is copied into the side info at that boundary.
    // ------------------------------------------------------------------
    sbca_pkg::div_state_t stage_in  [NS];
    sbca_pkg::div_state_t stage_out [NS];
    logic                 stage_vin [NS];
    logic                 stage_vout[NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_div
        if (i == 0)
        begin : g_first
            assign stage_in[i]  = s1_state_reg;
            assign stage_vin[i] = s1_valid_reg;
        end
        else if (i == sbca_pkg::MOD_STAGE)
        begin : g_mod_tap
            always_comb
            begin
                stage_in[i]              = stage_out[i-1];
                stage_in[i].info.mod_rem = stage_out[i-1].rem;
            end
            assign stage_vin[i] = stage_vout[i-1];
        end
        else
        begin : g_mid
            assign stage_in[i]  = stage_out[i-1];
            assign stage_vin[i] = stage_vout[i-1];
        end

        sbca_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (adv[i+1]),
            .in_valid  (stage_vin[i]),
            .in_state  (stage_in[i]),
            .out_valid (stage_vout[i]),
            .out_state (stage_out[i])
        );

        assign pipe_valid[i+1] = stage_vout[i];
    end

    // ------------------------------------------------------------------
    // Output register: pick the result source per opcode.
    // ------------------------------------------------------------------
    sbca_pkg::div_state_t last;
    logic [W-1:0]         result_value_next;
    logic [W-1:0]         overflow_value_next;
    logic [W-1:0]         result_value_reg;
    logic [W-1:0]         overflow_value_reg;
    logic                 writes_result_reg;
    logic                 writes_overflow_reg;
    logic                 skip_next_reg;
    logic                 out_valid_next;
    logic                 out_valid_reg;

    assign last = stage_out[NS-1];

    always_comb
    begin
        result_value_next   = last.info.side_res;
        overflow_value_next = last.info.side_ovf;
        case (last.info.op)
            sbca_pkg::OP_MUL:
            begin
                result_value_next   = last.info.product[W-1:0];
                overflow_value_next = last.info.product[2*W-1:W];
            end
            sbca_pkg::OP_DIV:
            begin
                // Divide by zero yields zero in both words.
                result_value_next   = last.info.b_zero ? '0 : last.word[2*W-1:W];
                overflow_value_next = last.info.b_zero ? '0 : last.word[W-1:0];
            end
            sbca_pkg::OP_MOD:
            begin
                result_value_next   = last.info.b_zero ? '0 : last.info.mod_rem;
                overflow_value_next = '0;
            end
            default: ;
        endcase
    end

    assign out_valid_next = adv[PD-1] ? stage_vout[NS-1] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[PD-1])
        begin
            result_value_reg    <= result_value_next;
            overflow_value_reg  <= overflow_value_next;
            writes_result_reg   <= last.info.wr;
            writes_overflow_reg <= last.info.wo;
            skip_next_reg       <= last.info.skip;
        end
    end

    assign pipe_valid[PD-1] = out_valid_reg;

    assign result.valid           = out_valid_reg;
    assign result.result_value    = result_value_reg;
    assign result.writes_result   = writes_result_reg;
    assign result.overflow_value  = overflow_value_reg;
    assign result.writes_overflow = writes_overflow_reg;
    assign result.skip_next       = skip_next_reg;

endmodule

>>> src/sbca_div_stage.sv
// One stage of the pipelined restoring divider: DIV_STEPS quotient bits per stage.
// Depends on sbca_pkg.
module sbca_div_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  in_valid,
    input  sbca_pkg::div_state_t  in_state,
    output logic                  out_valid,
    output sbca_pkg::div_state_t  out_state
);

    sbca_pkg::div_state_t           state_next;
    sbca_pkg::div_state_t           state_reg;
    logic                           valid_next;
    logic                           valid_reg;
    logic [sbca_pkg::WORD_W:0]      shifted;
    logic [sbca_pkg::WORD_W:0]      diff;

    always_comb
    begin
        state_next = in_state;
        shifted    = '0;
        diff       = '0;
        for (int i = 0; i < sbca_pkg::DIV_STEPS; i++)
        begin
            shifted = {state_next.rem, state_next.word[sbca_pkg::DIVD_W-1]};
            diff    = shifted - {1'b0, state_next.divisor};
            state_next.word = {state_next.word[sbca_pkg::DIVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, state_next.divisor})
            begin
                state_next.rem     = diff[sbca_pkg::WORD_W-1:0];
                state_next.word[0] = 1'b1;
            end
            else
            begin
                state_next.rem = shifted[sbca_pkg::WORD_W-1:0];
            end
        end
    end

    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

>>> src/sbca_checker.sv
// Port-level checks for the 16-bit CPU ALU, bound to the top level.
// Depends on sbca_pkg and sixteen_bit_cpu_alu.
module sbca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] result_value,
    input logic        writes_result,
    input logic [15:0] overflow_value,
    input logic        writes_overflow,
    input logic        skip_next
);

    localparam int CNT_W = $clog2(sbca_pkg::PIPE_DEPTH + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] outstanding_next;
    logic [CNT_W-1:0] outstanding_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign outstanding_next = outstanding_reg + CNT_W'(in_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(writes_result) && $stable(overflow_value)
            && $stable(writes_overflow) && $stable(skip_next))
        else $error("result changed while stalled");

    // No result without an item in flight.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != '0)
        else $error("result with nothing in flight");

    // Never more items in flight than pipeline registers.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CNT_W'(sbca_pkg::PIPE_DEPTH))
        else $error("items in flight exceed pipeline depth");

    // A full pipe with a stalled output takes nothing new.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == CNT_W'(sbca_pkg::PIPE_DEPTH) && !out_ready |-> !in_ready)
        else $error("item accepted while pipeline full and stalled");

endmodule

bind sixteen_bit_cpu_alu sbca_checker u_sbca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (instr.valid),
    .in_ready        (instr.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .result_value    (result.result_value),
    .writes_result   (result.writes_result),
    .overflow_value  (result.overflow_value),
    .writes_overflow (result.writes_overflow),
    .skip_next       (result.skip_next)
);

>>> dv/testbench.sv
// Self-checking testbench for sixteen_bit_cpu_alu: it drives instructions on the
// valid/ready channels and compares every result item with its own predictor.
// Depends on sbca_pkg, sbca_in_if, sbca_out_if and the ALU top level in src.
module testbench;

    // A full hold-off parks the result side and, once the pipeline fills, the input
    // too; the watchdog limit IDLE_LIMIT is ten times HOLD_CYCLES.
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_ITEMS   = 1880;
    // Final stretch of the random part runs with no idling on either side.
    localparam int CALM_TAIL    = 200;

    // One result item as the block should present it.
    typedef struct {
        logic [15:0] res;
        logic        wr;
        logic [15:0] ovf;
        logic        wo;
        logic        skip;
    } alu_out_t;

    // Holds the predicted result of every accepted instruction, oldest first,
    // and checks each result item against the head of that queue.
    class alu_result_board;
        alu_out_t pending_results[$];
        int       mismatches;

        function alu_out_t exec_instr(sbca_pkg::opcode_t op, logic [15:0] a,
                                      logic [15:0] b);
            alu_out_t    r;
            logic [47:0] wide;
            logic [31:0] dvd;
            r = '{res: 16'h0, wr: 1'b0, ovf: 16'h0, wo: 1'b0, skip: 1'b0};
            case (op)
                sbca_pkg::OP_SET: r.res = b;
                sbca_pkg::OP_ADD:
                begin
                    wide  = 48'(a) + 48'(b);
                    r.res = wide[15:0];
                    r.ovf = {15'h0, wide[16]};
                end
                sbca_pkg::OP_SUB:
                begin
                    r.res = a - b;
                    r.ovf = (a < b) ? 16'hFFFF : 16'h0;
                end
                sbca_pkg::OP_MUL:
                begin
                    wide  = 48'(a) * 48'(b);
                    r.res = wide[15:0];
                    r.ovf = wide[31:16];
                end
                sbca_pkg::OP_DIV:
                begin
                    if (b != 16'h0)
                    begin
                        r.res = a / b;
                        dvd   = {a, 16'h0} / {16'h0, b};
                        r.ovf = dvd[15:0];
                    end
                end
                sbca_pkg::OP_MOD: r.res = (b != 16'h0) ? a % b : 16'h0;
                sbca_pkg::OP_SHL:
                begin
                    if (b < 16'd32)
                    begin
                        wide  = {32'h0, a} << b[4:0];
                        r.res = wide[15:0];
                        r.ovf = wide[31:16];
                    end
                end
                sbca_pkg::OP_SHR:
                begin
                    if (b < 16'd32)
                    begin
                        dvd   = {a, 16'h0} >> b[4:0];
                        r.res = dvd[31:16];
                        r.ovf = dvd[15:0];
                    end
                end
                sbca_pkg::OP_AND: r.res = a & b;
                sbca_pkg::OP_BOR: r.res = a | b;
                sbca_pkg::OP_XOR: r.res = a ^ b;
                sbca_pkg::OP_IFE: r.skip = (a != b);
                sbca_pkg::OP_IFN: r.skip = (a == b);
                sbca_pkg::OP_IFG: r.skip = (a <= b);
                sbca_pkg::OP_IFB: r.skip = ((a & b) == 16'h0);
                default: ;
            endcase
            r.wr = (op >= sbca_pkg::OP_SET) && (op <= sbca_pkg::OP_XOR);
            r.wo = (op == sbca_pkg::OP_ADD) || (op == sbca_pkg::OP_SUB) ||
                   (op == sbca_pkg::OP_MUL) || (op == sbca_pkg::OP_DIV) ||
                   (op == sbca_pkg::OP_SHL) || (op == sbca_pkg::OP_SHR);
            return r;
        endfunction

        function void note_instr(sbca_pkg::opcode_t op, logic [15:0] a, logic [15:0] b);
            pending_results.push_back(exec_instr(op, a, b));
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (exp !== act)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            end
        endfunction

        function void check_result(alu_out_t got);
            alu_out_t exp;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with none expected, expected none, actual %h/%b",
                         $time, got.res, got.wr);
                return;
            end
            exp = pending_results.pop_front();
            compare_field("result_value",    exp.res,       got.res);
            compare_field("writes_result",   16'(exp.wr),   16'(got.wr));
            compare_field("overflow_value",  exp.ovf,       got.ovf);
            compare_field("writes_overflow", 16'(exp.wo),   16'(got.wo));
            compare_field("skip_next",       16'(exp.skip), 16'(got.skip));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sbca_in_if  instr_ch();
    sbca_out_if result_ch();

    alu_result_board board;

    // Knobs shared between the stimulus and the result-side ready driver.
    bit src_gaps;
    bit sink_stalls;
    bit hold_req;

    sixteen_bit_cpu_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitors: sample both channels at the rising edge. An instruction is
    // predicted the moment it is accepted; a result is checked when taken.
    initial
    begin
        alu_out_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && instr_ch.valid && instr_ch.ready)
                board.note_instr(sbca_pkg::opcode_t'(instr_ch.cmd),
                                 instr_ch.a_value, instr_ch.b_value);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.res  = result_ch.result_value;
                got.wr   = result_ch.writes_result;
                got.ovf  = result_ch.overflow_value;
                got.wo   = result_ch.writes_overflow;
                got.skip = result_ch.skip_next;
                board.check_result(got);
            end
        end
    end

    // Watchdog: cycles in a row where neither channel moves an item.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[sixteen_bit_cpu_alu] ERROR");
                $finish;
            end
        end
    end

    // Result-side ready. Random low bursts while enabled; on request a long
    // hold-off so the pipeline backs up into the input.
    // At most one assignment to ready per falling edge.
    initial
    begin
        int burst;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                burst = $urandom_range(1, 10);
                repeat (burst - 1) @(negedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Offer one instruction, optionally after an idle burst, and hold it until
    // accepted. Entered and left at a falling edge; valid stays high on exit so
    // back-to-back items keep it high without a glitch.
    task automatic do_instr(sbca_pkg::opcode_t op, logic [15:0] a, logic [15:0] b);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            instr_ch.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
        end
        instr_ch.valid   <= 1'b1;
        instr_ch.cmd     <= op;
        instr_ch.a_value <= a;
        instr_ch.b_value <= b;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait for every predicted result to come back.
    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending_results.size() != 0);
    endtask

    // Operand values weighted toward the word's corners.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'h8000;
            4: return 16'h7FFF;
            5: return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic rand_instr();
        sbca_pkg::opcode_t op;
        logic [15:0]       a;
        logic [15:0]       b;
        op = sbca_pkg::opcode_t'($urandom_range(0, 15));
        a  = pick_word();
        b  = pick_word();
        case (op) inside
            // Mostly in-range shift counts, with the 32-and-up cases still hit.
            sbca_pkg::OP_SHL, sbca_pkg::OP_SHR:
                if ($urandom_range(0, 3) != 0)
                    b = 16'($urandom_range(0, 40));
            // Small divisors, zero included.
            sbca_pkg::OP_DIV, sbca_pkg::OP_MOD:
                if ($urandom_range(0, 3) == 0)
                    b = 16'($urandom_range(0, 16));
            // Sometimes equal operands, so the compare tests see both outcomes.
            sbca_pkg::OP_IFE, sbca_pkg::OP_IFN, sbca_pkg::OP_IFG:
                if ($urandom_range(0, 2) == 0)
                    b = a;
            default: ;
        endcase
        do_instr(op, a, b);
    endtask

    initial
    begin
        board = new();
        rst_n            = 1'b0;
        instr_ch.valid   = 1'b0;
        instr_ch.cmd     = sbca_pkg::OP_NONBASIC;
        instr_ch.a_value = 16'h0;
        instr_ch.b_value = 16'h0;
        result_ch.ready  = 1'b0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        hold_req    = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: each opcode, carries and borrows, divide and mod by zero,
        // shifts at and past the word, and one outcome of every test.
        do_instr(sbca_pkg::OP_NONBASIC, 16'hFFFF, 16'hFFFF);
        do_instr(sbca_pkg::OP_SET, 16'h0000, 16'hFFFF);
        do_instr(sbca_pkg::OP_ADD, 16'hFFFF, 16'h0001);
        do_instr(sbca_pkg::OP_ADD, 16'h1234, 16'h0001);
        do_instr(sbca_pkg::OP_SUB, 16'h0000, 16'h0001);
        do_instr(sbca_pkg::OP_SUB, 16'hFFFF, 16'hFFFF);
        do_instr(sbca_pkg::OP_MUL, 16'hFFFF, 16'hFFFF);
        do_instr(sbca_pkg::OP_DIV, 16'h0007, 16'h0000);
        do_instr(sbca_pkg::OP_DIV, 16'h0001, 16'h0003);
        do_instr(sbca_pkg::OP_DIV, 16'hFFFF, 16'h0001);
        do_instr(sbca_pkg::OP_MOD, 16'h0007, 16'h0000);
        do_instr(sbca_pkg::OP_MOD, 16'hFFFF, 16'h000A);
        do_instr(sbca_pkg::OP_SHL, 16'hFFFF, 16'h0010);
        do_instr(sbca_pkg::OP_SHL, 16'h0001, 16'h001F);
        do_instr(sbca_pkg::OP_SHL, 16'hFFFF, 16'h0020);
        do_instr(sbca_pkg::OP_SHR, 16'h8000, 16'h0001);
        do_instr(sbca_pkg::OP_SHR, 16'hFFFF, 16'h001F);
        do_instr(sbca_pkg::OP_SHR, 16'hFFFF, 16'hFFFF);
        do_instr(sbca_pkg::OP_AND, 16'hF0F0, 16'hFF00);
        do_instr(sbca_pkg::OP_BOR, 16'hF0F0, 16'h0F0F);
        do_instr(sbca_pkg::OP_XOR, 16'hFFFF, 16'h5A5A);
        do_instr(sbca_pkg::OP_IFE, 16'hFFFF, 16'hFFFF);
        do_instr(sbca_pkg::OP_IFN, 16'h0000, 16'h0000);
        do_instr(sbca_pkg::OP_IFG, 16'h0001, 16'h0001);
        do_instr(sbca_pkg::OP_IFB, 16'hAAAA, 16'h5555);
        drain_results();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // Hold-off window: keep pushing with no gaps while the result side
            // is parked, so the pipeline fills and input ready drops.
            if (i == 600)
                hold_req = 1'b1;
            // Sender pause mid-run until the pipeline is empty.
            if (i == 1300)
                drain_results();
            src_gaps    = !(i >= 600 && i < 640) && !(i >= 1000 && i < 1150) &&
                          (i < RAND_ITEMS - CALM_TAIL);
            sink_stalls = !(i >= 1000 && i < 1150) && (i < RAND_ITEMS - CALM_TAIL);
            rand_instr();
        end
        instr_ch.valid <= 1'b0;

        // Let the pipeline empty, then wait on to catch strays.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (sbca_pkg::PIPE_DEPTH + 4) @(posedge clk);

        if (board.mismatches == 0)
            $display("[sixteen_bit_cpu_alu] OK");
        else
            $display("[sixteen_bit_cpu_alu] ERROR");
        $finish;
    end
endmodule
